[rtl/bot_rws_pkg.sv]
// Package with shared types, codes and constants for the read/write sequencer.
`default_nettype none
package bot_rws_pkg;

  localparam int unsigned SECTOR_BYTES_LOG2 = 9;
  localparam int unsigned CHUNK_SECTORS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam logic [31:0] CSW_SIGNATURE = 32'h5342_5355;
  localparam logic [7:0]  OPC_READ      = 8'h28;
  localparam logic [7:0]  OPC_WRITE     = 8'h2A;
  localparam logic [15:0] CSW_MIN_BYTES = 16'd13;
  localparam logic [7:0]  CSW_PHASE_ERR = 8'd2;

  localparam logic [1:0] OUTC_OK    = 2'd0;
  localparam logic [1:0] OUTC_STALL = 2'd1;

  localparam logic [2:0] ACT_CBW   = 3'd0;
  localparam logic [2:0] ACT_DATA  = 3'd1;
  localparam logic [2:0] ACT_CSW   = 3'd2;
  localparam logic [2:0] ACT_HALT  = 3'd3;
  localparam logic [2:0] ACT_RESET = 3'd4;
  localparam logic [2:0] ACT_OK    = 3'd5;
  localparam logic [2:0] ACT_FAIL  = 3'd6;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 104;

  typedef struct packed {
    logic        two;
    logic [2:0]  act0;
    logic [2:0]  act1;
    logic        halt_in;
    logic [31:0] tag;
    logic [31:0] lba;
    logic [6:0]  chunk;
    logic        wmode;
  } bot_rws_entry_t;

endpackage
`default_nettype wire

[rtl/bot_rws_front.sv]
// Front end: accepts items, tracks the transport state and queues result descriptors.
`default_nettype none
module bot_rws_front
  import bot_rws_pkg::*;
#(
  parameter int unsigned CHUNK_SECTORS = CHUNK_SECTORS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [31:0]          cfg_wr_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output bot_rws_entry_t            q_entry
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CBW  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CSW  = 2'd3;
  localparam logic [31:0] CHUNK32 = 32'(CHUNK_SECTORS);
  localparam logic [6:0]  CHUNK7  = 7'(CHUNK_SECTORS);

  logic [31:0] cap_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] lba_r, lba_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [6:0]  chunk_r, chunk_nxt;
  logic        wmode_r, wmode_nxt;
  logic        retried_r, retried_nxt;

  logic        is_write;
  logic [31:0] start_lba, sector_count, sig, tag_in, residue;
  logic [1:0]  outcome;
  logic [15:0] bytes_moved;
  logic [7:0]  code;
  logic        accept;
  logic        produce, two, halt_in;
  logic [2:0]  act0, act1;
  logic        range_bad;
  logic [31:0] rem_after;
  logic [31:0] issue_rem;
  logic        issue;

  assign is_write     = in_tdata[0];
  assign start_lba    = in_tdata[32:1];
  assign sector_count = in_tdata[64:33];
  assign outcome      = in_tdata[66:65];
  assign bytes_moved  = in_tdata[82:67];
  assign sig          = in_tdata[114:83];
  assign tag_in       = in_tdata[146:115];
  assign residue      = in_tdata[178:147];
  assign code         = in_tdata[186:179];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign range_bad = (cap_r == 32'd0) || (sector_count == 32'd0) || (start_lba >= cap_r) ||
                     (sector_count > (cap_r - start_lba));
  assign rem_after = rem_r - {25'd0, chunk_r};

  always_comb begin
    phase_nxt   = phase_r;
    tag_nxt     = tag_r;
    lba_nxt     = lba_r;
    rem_nxt     = rem_r;
    chunk_nxt   = chunk_r;
    wmode_nxt   = wmode_r;
    retried_nxt = retried_r;
    produce     = 1'b0;
    two         = 1'b0;
    halt_in     = 1'b0;
    act0        = ACT_FAIL;
    act1        = ACT_FAIL;
    issue       = 1'b0;
    issue_rem   = rem_r;
    if (accept) begin
      if (!in_tuser) begin
        if (phase_r == PH_IDLE) begin
          produce = 1'b1;
          if (!range_bad) begin
            wmode_nxt   = is_write;
            lba_nxt     = start_lba;
            rem_nxt     = sector_count;
            retried_nxt = 1'b0;
            issue       = 1'b1;
            issue_rem   = sector_count;
          end
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_CBW: begin
            produce = 1'b1;
            if (outcome == OUTC_OK) begin
              phase_nxt = PH_DATA;
              act0      = ACT_DATA;
            end else begin
              phase_nxt = PH_IDLE;
              two       = 1'b1;
              act0      = ACT_RESET;
            end
          end
          PH_DATA: begin
            produce = 1'b1;
            if (outcome == OUTC_OK || outcome == OUTC_STALL) begin
              phase_nxt   = PH_CSW;
              retried_nxt = 1'b0;
              if (outcome == OUTC_STALL) begin
                two     = 1'b1;
                act0    = ACT_HALT;
                halt_in = !wmode_r;
                act1    = ACT_CSW;
              end else begin
                act0 = ACT_CSW;
              end
            end else begin
              phase_nxt = PH_IDLE;
              two       = 1'b1;
              act0      = ACT_RESET;
            end
          end
          PH_CSW: begin
            produce = 1'b1;
            if (outcome == OUTC_STALL && !retried_r) begin
              retried_nxt = 1'b1;
              two         = 1'b1;
              act0        = ACT_HALT;
              halt_in     = 1'b1;
              act1        = ACT_CSW;
            end else if (outcome != OUTC_OK || bytes_moved < CSW_MIN_BYTES ||
                         sig != CSW_SIGNATURE || tag_in != tag_r ||
                         code == CSW_PHASE_ERR) begin
              phase_nxt = PH_IDLE;
              two       = 1'b1;
              act0      = ACT_RESET;
            end else if (code != 8'd0 || residue != 32'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              lba_nxt = lba_r + {25'd0, chunk_r};
              rem_nxt = rem_after;
              if (rem_after == 32'd0) begin
                phase_nxt = PH_IDLE;
                act0      = ACT_OK;
              end else begin
                issue     = 1'b1;
                issue_rem = rem_after;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (issue) begin
      chunk_nxt = (issue_rem > CHUNK32) ? CHUNK7 : issue_rem[6:0];
      tag_nxt   = tag_r + 32'd1;
      phase_nxt = PH_CBW;
      act0      = ACT_CBW;
    end
  end

  assign q_push          = produce;
  assign q_entry.two     = two;
  assign q_entry.act0    = act0;
  assign q_entry.act1    = act1;
  assign q_entry.halt_in = halt_in;
  assign q_entry.tag     = tag_nxt;
  assign q_entry.lba     = lba_nxt;
  assign q_entry.chunk   = chunk_nxt;
  assign q_entry.wmode   = wmode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= 32'd0;
      phase_r   <= PH_IDLE;
      tag_r     <= 32'd0;
      lba_r     <= 32'd0;
      rem_r     <= 32'd0;
      chunk_r   <= 7'd0;
      wmode_r   <= 1'b0;
      retried_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      phase_r   <= phase_nxt;
      tag_r     <= tag_nxt;
      lba_r     <= lba_nxt;
      rem_r     <= rem_nxt;
      chunk_r   <= chunk_nxt;
      wmode_r   <= wmode_nxt;
      retried_r <= retried_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/bot_rws_queue.sv]
// Small register queue of result descriptors between the front and back ends.
`default_nettype none
module bot_rws_queue
  import bot_rws_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bot_rws_entry_t  push_entry,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output bot_rws_entry_t       head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  bot_rws_entry_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/bot_rws_back.sv]
// Back end: expands queued descriptors into result items behind an output register.
`default_nettype none
module bot_rws_back
  import bot_rws_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_not_empty,
  input  wire bot_rws_entry_t        q_head,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  logic                  valid_r;
  logic                  idx_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  last_r;
  logic                  load;
  logic                  is_last;
  logic [2:0]            act;
  logic [OUT_DATA_W-1:0] data_nxt;

  assign load    = q_not_empty && (!valid_r || out_tready);
  assign act     = idx_r ? q_head.act1 : q_head.act0;
  assign is_last = idx_r || !q_head.two;
  assign q_pop   = load && is_last;

  always_comb begin
    data_nxt       = '0;
    data_nxt[2:0]  = act;
    if (act <= ACT_HALT) begin
      data_nxt[34:3]  = q_head.tag;
      data_nxt[50:35] = {q_head.chunk, {SECTOR_BYTES_LOG2{1'b0}}};
      data_nxt[51]    = !q_head.wmode;
      data_nxt[59:52] = q_head.wmode ? OPC_WRITE : OPC_READ;
      data_nxt[91:60] = q_head.lba;
      data_nxt[98:92] = q_head.chunk;
    end
    if (act == ACT_HALT) begin
      data_nxt[99] = q_head.halt_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= !is_last;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

[rtl/bot_read_write_sequencer_unit.sv]
// Top level of the Bulk-Only Transport read/write sequencer.
//
// The front end takes one input item per cycle as long as its four-entry descriptor
// queue has room, updates the transport state in that same cycle and queues what the
// item causes; the back end turns each descriptor into one or two result items and
// sends one result item per cycle through its output register while out_tready is high.
// The first result of an item passes through the descriptor queue and then the output
// register. The user writes the capacity register through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module bot_read_write_sequencer_unit
  import bot_rws_pkg::*;
#(
  parameter int unsigned CHUNK_SECTORS = CHUNK_SECTORS_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [31:0]           cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // is_write, start_lba, sector_count, outcome, bytes_moved, status_signature,
  // status_tag, status_residue, status_code, then zero fill.
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command.
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // action, cbw_tag, data_length, data_in, scsi_opcode, chunk_lba, chunk_blocks,
  // halt_in_endpoint, then zero fill.
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  logic           q_push, q_pop, q_full, q_not_empty;
  bot_rws_entry_t q_entry, q_head;

  bot_rws_front #(
    .CHUNK_SECTORS(CHUNK_SECTORS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  bot_rws_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bot_rws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] >= ACT_RESET) |-> (out_tdata[99:3] == '0))
    else $error("Completion or reset item carries chunk fields.");

  a_halt_only_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[99]) |-> (out_tdata[2:0] == ACT_HALT))
    else $error("Halt endpoint flag set on a non-clear-halt item.");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == ACT_OK || out_tdata[2:0] == ACT_FAIL ||
                    out_tdata[2:0] == ACT_CBW || out_tdata[2:0] == ACT_DATA))
    |-> out_tlast)
    else $error("Final action of an input not marked last.");

  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] == ACT_HALT || out_tdata[2:0] == ACT_RESET))
    |-> !out_tlast)
    else $error("Leading item of a pair marked last.");

endmodule
`default_nettype wire

[tb/bot_rws_action_board_pkg.sv]
// Item layouts, transfer phases and the bus action scoreboard for the read/write sequencer bench.
package bot_rws_action_board_pkg;
  import bot_rws_pkg::*;

  localparam bit         CMD_REQUEST = 1'b0;
  localparam bit         CMD_OUTCOME = 1'b1;
  localparam logic [1:0] OUTC_ERROR  = 2'd2;
  localparam logic [1:0] OUTC_BAD    = 2'd3;
  localparam logic [7:0] CSW_PASSED  = 8'd0;
  localparam logic [6:0] CHUNK_MAX   = 7'(CHUNK_SECTORS_DEF);

  typedef enum logic [1:0] {XFER_IDLE, XFER_CBW, XFER_DATA, XFER_CSW} xfer_phase_e;

  typedef struct packed {
    logic [4:0]  fill;
    logic [7:0]  status_code;
    logic [31:0] status_residue;
    logic [31:0] status_tag;
    logic [31:0] status_signature;
    logic [15:0] bytes_moved;
    logic [1:0]  outcome;
    logic [31:0] sector_count;
    logic [31:0] start_lba;
    logic        is_write;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  fill;
    logic        halt_in;
    logic [6:0]  chunk_blocks;
    logic [31:0] chunk_lba;
    logic [7:0]  scsi_opcode;
    logic        data_in;
    logic [15:0] data_length;
    logic [31:0] cbw_tag;
    logic [2:0]  action;
  } action_word_t;

  typedef struct packed {
    action_word_t word;
    logic         tlast;
  } bus_action_t;

  class bus_action_board;
    logic [31:0] capacity;
    xfer_phase_e phase;
    logic [31:0] tag_count;
    logic [31:0] cur_lba;
    logic [31:0] remaining;
    logic [6:0]  cur_chunk;
    bit          write_mode;
    bit          csw_retried;
    bus_action_t pending_actions[$];
    int          mismatches;

    function new();
      capacity    = '0;
      phase       = XFER_IDLE;
      tag_count   = '0;
      cur_lba     = '0;
      remaining   = '0;
      cur_chunk   = '0;
      write_mode  = 1'b0;
      csw_retried = 1'b0;
      mismatches  = 0;
    endfunction

    function void push_action(logic [2:0] act, bit halt_in);
      bus_action_t e;
      e = '0;
      e.word.action = act;
      if (act <= ACT_HALT) begin
        e.word.cbw_tag      = tag_count;
        e.word.data_length  = 16'(cur_chunk) << SECTOR_BYTES_LOG2;
        e.word.data_in      = !write_mode;
        e.word.scsi_opcode  = write_mode ? OPC_WRITE : OPC_READ;
        e.word.chunk_lba    = cur_lba;
        e.word.chunk_blocks = cur_chunk;
      end
      if (act == ACT_HALT) begin
        e.word.halt_in = halt_in;
      end
      pending_actions.push_back(e);
    endfunction

    function void issue_chunk();
      cur_chunk = (remaining > 32'(CHUNK_MAX)) ? CHUNK_MAX : remaining[6:0];
      tag_count = tag_count + 1;
      phase     = XFER_CBW;
      push_action(ACT_CBW, 1'b0);
    endfunction

    function void abort_with_reset();
      phase = XFER_IDLE;
      push_action(ACT_RESET, 1'b0);
      push_action(ACT_FAIL, 1'b0);
    endfunction

    function void note_input(bit cmd, req_item_t it);
      int first;
      first = pending_actions.size();
      if (cmd == CMD_REQUEST) begin
        if (phase == XFER_IDLE) begin
          if (capacity == 0 || it.sector_count == 0 || it.start_lba >= capacity ||
              it.sector_count > capacity - it.start_lba) begin
            push_action(ACT_FAIL, 1'b0);
          end else begin
            write_mode  = it.is_write;
            cur_lba     = it.start_lba;
            remaining   = it.sector_count;
            csw_retried = 1'b0;
            issue_chunk();
          end
        end
      end else begin
        case (phase)
          XFER_CBW: begin
            if (it.outcome == OUTC_OK) begin
              phase = XFER_DATA;
              push_action(ACT_DATA, 1'b0);
            end else begin
              abort_with_reset();
            end
          end
          XFER_DATA: begin
            if (it.outcome == OUTC_OK || it.outcome == OUTC_STALL) begin
              if (it.outcome == OUTC_STALL) begin
                push_action(ACT_HALT, !write_mode);
              end
              phase       = XFER_CSW;
              csw_retried = 1'b0;
              push_action(ACT_CSW, 1'b0);
            end else begin
              abort_with_reset();
            end
          end
          XFER_CSW: begin
            if (it.outcome == OUTC_STALL && !csw_retried) begin
              csw_retried = 1'b1;
              push_action(ACT_HALT, 1'b1);
              push_action(ACT_CSW, 1'b0);
            end else if (it.outcome != OUTC_OK || it.bytes_moved < CSW_MIN_BYTES) begin
              abort_with_reset();
            end else if (it.status_signature != CSW_SIGNATURE || it.status_tag != tag_count ||
                         it.status_code == CSW_PHASE_ERR) begin
              abort_with_reset();
            end else if (it.status_code != CSW_PASSED || it.status_residue != 0) begin
              phase = XFER_IDLE;
              push_action(ACT_FAIL, 1'b0);
            end else begin
              cur_lba   = cur_lba + 32'(cur_chunk);
              remaining = remaining - 32'(cur_chunk);
              if (remaining == 0) begin
                phase = XFER_IDLE;
                push_action(ACT_OK, 1'b0);
              end else begin
                issue_chunk();
              end
            end
          end
          default: ;
        endcase
      end
      if (pending_actions.size() > first) begin
        pending_actions[$].tlast = 1'b1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic tlast);
      bus_action_t  e;
      action_word_t got;
      bit           bad;
      got = action_word_t'(data);
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result item: tdata %h tlast %b", data, tlast);
        end
        return;
      end
      e = pending_actions.pop_front();
      bad = (got.action !== e.word.action) || (got.cbw_tag !== e.word.cbw_tag) ||
            (got.data_length !== e.word.data_length) || (got.data_in !== e.word.data_in) ||
            (got.scsi_opcode !== e.word.scsi_opcode) || (got.chunk_lba !== e.word.chunk_lba) ||
            (got.chunk_blocks !== e.word.chunk_blocks) || (got.halt_in !== e.word.halt_in) ||
            (got.fill !== '0) || (tlast !== e.tlast);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: act %0d tag %h len %0d in %b opc %h lba %h blk %0d halt %b last %b",
                   e.word.action, e.word.cbw_tag, e.word.data_length, e.word.data_in,
                   e.word.scsi_opcode, e.word.chunk_lba, e.word.chunk_blocks, e.word.halt_in,
                   e.tlast);
          $display("         actual:   act %0d tag %h len %0d in %b opc %h lba %h blk %0d halt %b last %b",
                   got.action, got.cbw_tag, got.data_length, got.data_in, got.scsi_opcode,
                   got.chunk_lba, got.chunk_blocks, got.halt_in, tlast);
        end
      end
    endfunction
  endclass

endpackage

[tb/tb_bot_read_write_sequencer_unit.sv]
// Testbench top that drives requests and phase outcomes into the sequencer and checks its bus actions.
module tb_bot_read_write_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bot_rws_pkg::*;
  import bot_rws_action_board_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [31:0]           cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  bus_action_board board = new();
  int  send_idle_pct = 8;
  int  recv_idle_pct = 72;
  bit  hold_request = 1'b0;
  int  quiet_cycles = 0;

  bot_read_write_sequencer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
        hold_request = 1'b0;
      end
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_item_t random_fields();
    req_item_t it;
    it = '0;
    it.is_write         = 1'($urandom_range(1));
    it.start_lba        = $urandom();
    it.sector_count     = $urandom();
    it.outcome          = 2'($urandom_range(3));
    it.bytes_moved      = 16'($urandom_range(65535));
    it.status_signature = $urandom();
    it.status_tag       = $urandom();
    it.status_residue   = $urandom();
    it.status_code      = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_item(bit cmd, req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    board.note_input(cmd, it);
  endtask

  task automatic send_request(bit wr, logic [31:0] lba, logic [31:0] count);
    req_item_t it;
    it = random_fields();
    it.is_write     = wr;
    it.start_lba    = lba;
    it.sector_count = count;
    send_item(CMD_REQUEST, it);
  endtask

  task automatic send_status(logic [1:0] outc, logic [15:0] bytes, logic [31:0] sig,
                             logic [31:0] tag, logic [31:0] residue, logic [7:0] code);
    req_item_t it;
    it = random_fields();
    it.outcome          = outc;
    it.bytes_moved      = bytes;
    it.status_signature = sig;
    it.status_tag       = tag;
    it.status_residue   = residue;
    it.status_code      = code;
    send_item(CMD_OUTCOME, it);
  endtask

  task automatic send_outcome(logic [1:0] outc);
    req_item_t it;
    it = random_fields();
    it.outcome = outc;
    send_item(CMD_OUTCOME, it);
  endtask

  task automatic send_good_status();
    send_status(OUTC_OK, CSW_MIN_BYTES, CSW_SIGNATURE, board.tag_count, '0, CSW_PASSED);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_actions.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    if (board.phase != XFER_IDLE) begin
      send_outcome(OUTC_ERROR);
    end
    drain_outputs();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.capacity = value;
  endtask

  // Mostly well-formed transfers with occasional stalls, errors and corrupt status words.
  task automatic random_step(output bit useful);
    req_item_t   it;
    int          r;
    logic [31:0] room;
    it = random_fields();
    r  = $urandom_range(99);
    useful = 1'b1;
    if (board.phase == XFER_IDLE) begin
      if (r < 85 && board.capacity != 0) begin
        it.start_lba    = $urandom_range(board.capacity - 1, 0);
        room            = board.capacity - it.start_lba;
        it.sector_count = ($urandom_range(9) < 8) ? $urandom_range((room > 200) ? 200 : room, 1)
                                                  : $urandom_range(room, 1);
        send_item(CMD_REQUEST, it);
      end else if (r < 92) begin
        if ($urandom_range(4) == 0) begin
          it.sector_count = '0;
        end
        send_item(CMD_REQUEST, it);
      end else begin
        send_item(CMD_OUTCOME, it);
        useful = 1'b0;
      end
    end else if (r < 5) begin
      send_item(CMD_REQUEST, it);
      useful = 1'b0;
    end else begin
      case (board.phase)
        XFER_CBW: begin
          it.outcome = (r < 85) ? OUTC_OK : (r < 92) ? OUTC_STALL : 2'($urandom_range(3, 2));
        end
        XFER_DATA: begin
          it.outcome = (r < 75) ? OUTC_OK : (r < 87) ? OUTC_STALL : 2'($urandom_range(3, 2));
        end
        default: begin
          it.outcome          = OUTC_OK;
          it.bytes_moved      = 16'($urandom_range(65535, 13));
          it.status_signature = CSW_SIGNATURE;
          it.status_tag       = board.tag_count;
          it.status_residue   = '0;
          it.status_code      = CSW_PASSED;
          if (r >= 60 && r < 72) begin
            it.outcome = OUTC_STALL;
          end else if (r >= 72) begin
            case ($urandom_range(6))
              0: it.bytes_moved      = 16'($urandom_range(12));
              1: it.status_signature = $urandom();
              2: it.status_tag       = board.tag_count ^ (32'd1 << $urandom_range(31));
              3: it.status_code      = CSW_PHASE_ERR;
              4: it.status_code      = 8'($urandom_range(255, 1));
              5: it.status_residue   = $urandom() | (32'd1 << $urandom_range(31));
              default: it.outcome    = 2'($urandom_range(3, 2));
            endcase
          end
        end
      endcase
      send_item(CMD_OUTCOME, it);
    end
  endtask

  task automatic run_random(int count);
    int done;
    bit useful;
    done = 0;
    while (done < count) begin
      random_step(useful);
      if (useful) begin
        done++;
      end
    end
  endtask

  initial begin
    logic [31:0] caps [6];
    int          counts [6];
    caps   = '{32'd300, 32'd1, 32'hFFFF_FFFF, $urandom(), 32'd0, 32'd128};
    counts = '{170, 120, 200, 170, 40, 200};
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_REQUEST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(1'b0, 32'd0, 32'd1);
    send_outcome(OUTC_OK);
    write_capacity(32'd1000);
    send_request(1'b0, 32'd5, 32'd0);
    send_request(1'b1, 32'd1000, 32'd1);
    send_request(1'b1, 32'd999, 32'd2);
    send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'd10, 32'd100);
    send_request(1'b1, 32'd0, 32'd1);
    send_outcome(OUTC_OK);
    send_outcome(OUTC_STALL);
    send_status(OUTC_STALL, '0, '0, '0, '0, '0);
    send_good_status();
    send_outcome(OUTC_OK);
    send_outcome(OUTC_OK);
    send_status(OUTC_STALL, '0, '0, '0, '0, '0);
    send_status(OUTC_STALL, '0, '0, '0, '0, '0);
    send_request(1'b1, 32'd999, 32'd1);
    send_outcome(OUTC_STALL);
    send_request(1'b1, 32'd0, 32'd64);
    send_outcome(OUTC_OK);
    send_outcome(OUTC_STALL);
    send_good_status();
    send_request(1'b0, 32'd0, 32'd1);
    send_outcome(OUTC_OK);
    send_outcome(OUTC_BAD);

    for (int p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      send_idle_pct = (p < 2) ? 8 : (p < 4) ? 72 : 0;
      recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 8 : 0;
      if (p == 5) begin
        hold_request = 1'b1;
      end
      run_random(counts[p]);
    end

    drain_outputs();
    if (board.mismatches == 0 && board.pending_actions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
